/* design/mqv_pkg.sv */
package mqv_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = LenW + 1;
  localparam int unsigned CpW    = 21;

  localparam logic [LenW-1:0] MaxLenReset = 16'hFFFF;

  // Code point limits from RFC 3629.
  localparam logic [CpW-1:0] CpMin2      = 21'h000080;
  localparam logic [CpW-1:0] CpMin3      = 21'h000800;
  localparam logic [CpW-1:0] CpMin4      = 21'h010000;
  localparam logic [CpW-1:0] CpSurrLo    = 21'h00D800;
  localparam logic [CpW-1:0] CpSurrHi    = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMax       = 21'h10FFFF;

  localparam logic [DataW-1:0] CtlLastLow = 8'h1F;
  localparam logic [DataW-1:0] CtlDel     = 8'h7F;
  localparam logic [DataW-1:0] LeadC2     = 8'hC2;
  localparam logic [DataW-1:0] C1Lo       = 8'h80;
  localparam logic [DataW-1:0] C1Hi       = 8'h9F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_BAD_UTF8 = 2'd2,
    ST_CONTROL  = 2'd3
  } status_e;

  // Running state of the string being checked.
  typedef struct packed {
    logic [1:0]        pending;
    logic [1:0]        kind;
    logic [CpW-1:0]    accum;
    logic              prev_c2;
    logic [CountW-1:0] byte_count;
    logic              utf8_err;
    logic              control_seen;
  } str_state_t;

endpackage

/* design/mqv_step.sv */
module mqv_step (
  input  mqv_pkg::str_state_t         state_i,
  input  logic [mqv_pkg::DataW-1:0]   byte_i,
  input  logic                        no_byte_i,
  input  logic [mqv_pkg::LenW-1:0]    max_len_i,
  output mqv_pkg::str_state_t         state_o,
  output mqv_pkg::status_e            status_o
);

  mqv_pkg::str_state_t        nxt;
  logic [mqv_pkg::CpW-1:0]    acc;
  logic [mqv_pkg::CountW-1:0] max_ext;

  assign max_ext = {1'b0, max_len_i};
  assign acc     = {state_i.accum[mqv_pkg::CpW-7:0], byte_i[5:0]};

  always_comb begin
    nxt = state_i;
    if (!no_byte_i) begin
      if (state_i.byte_count <= max_ext) begin
        nxt.byte_count = state_i.byte_count + mqv_pkg::CountW'(1);
      end
      if (byte_i <= mqv_pkg::CtlLastLow || byte_i == mqv_pkg::CtlDel ||
          (state_i.prev_c2 && byte_i >= mqv_pkg::C1Lo && byte_i <= mqv_pkg::C1Hi)) begin
        nxt.control_seen = 1'b1;
      end
      nxt.prev_c2 = (byte_i == mqv_pkg::LeadC2);

      if (state_i.pending == 2'd0) begin
        // Expecting a lead byte; plain ASCII leaves the decoder alone.
        if (!byte_i[7]) begin
          nxt.pending = 2'd0;
        end else if (byte_i[7:5] == 3'b110) begin
          nxt.kind    = 2'd1;
          nxt.pending = 2'd1;
          nxt.accum   = {16'd0, byte_i[4:0]};
        end else if (byte_i[7:4] == 4'b1110) begin
          nxt.kind    = 2'd2;
          nxt.pending = 2'd2;
          nxt.accum   = {17'd0, byte_i[3:0]};
        end else if (byte_i[7:3] == 5'b11110) begin
          nxt.kind    = 2'd3;
          nxt.pending = 2'd3;
          nxt.accum   = {18'd0, byte_i[2:0]};
        end else begin
          nxt.utf8_err = 1'b1;
        end
      end else if (byte_i[7:6] != 2'b10) begin
        nxt.utf8_err = 1'b1;
        nxt.pending  = 2'd0;
      end else begin
        nxt.accum   = acc;
        nxt.pending = state_i.pending - 2'd1;
        if (state_i.pending == 2'd1) begin
          if ((state_i.kind == 2'd1 && acc < mqv_pkg::CpMin2) ||
              (state_i.kind == 2'd2 && acc < mqv_pkg::CpMin3) ||
              (state_i.kind == 2'd3 && acc < mqv_pkg::CpMin4) ||
              (acc >= mqv_pkg::CpSurrLo && acc <= mqv_pkg::CpSurrHi) ||
              acc > mqv_pkg::CpMax) begin
            nxt.utf8_err = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    if (nxt.byte_count > max_ext) begin
      status_o = mqv_pkg::ST_TOO_LONG;
    end else if (nxt.utf8_err || nxt.pending != 2'd0) begin
      status_o = mqv_pkg::ST_BAD_UTF8;
    end else if (nxt.control_seen) begin
      status_o = mqv_pkg::ST_CONTROL;
    end else begin
      status_o = mqv_pkg::ST_OK;
    end
  end

  assign state_o = nxt;

endmodule

/* design/mqtt_utf8_string_validator_unit.sv */
// Flow: each word is registered in the input register; the word that ends a string moves on
// into the result register once that register is free or is being emptied.
// Throughput: one byte word per cycle while the result register can take the status of
// each string end, and results can leave back to back.
// Reset (rst_ni low, asynchronous) empties both registers and clears the string
// state; the length limit returns to 65535.
module mqtt_utf8_string_validator_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Length limit register.
  input  logic                       cfg_we_i,
  input  logic [mqv_pkg::LenW-1:0]   cfg_wdata_i,
  // Byte stream.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
  input  logic                       s_axis_tuser,   // [0] no_byte
  input  logic                       s_axis_tlast,   // end of string
  // Status stream, one word per string.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata    // [1:0] status, [7:2] zero
);

  // The input register holds one word. The string state and the result register
  // sit behind it. A word that does not end a string always moves on; a word
  // that ends a string moves on only when the result register is free or is
  // being emptied in the same cycle.
  logic                      in_vld_q;
  logic [mqv_pkg::DataW-1:0] in_byte_q;
  logic                      in_nob_q;
  logic                      in_last_q;

  logic [mqv_pkg::LenW-1:0]  max_len_q;
  mqv_pkg::str_state_t       str_q, str_next;
  mqv_pkg::status_e          status_next;

  logic                      out_vld_q;
  mqv_pkg::status_e          out_status_q;

  logic out_free;
  logic adv;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mqv_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_nob_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  mqv_step u_step (
    .state_i   (str_q),
    .byte_i    (in_byte_q),
    .no_byte_i (in_nob_q),
    .max_len_i (max_len_q),
    .state_o   (str_next),
    .status_o  (status_next)
  );

  // The end of a string wipes the state so the next word starts fresh.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      str_q <= '0;
    end else if (adv) begin
      str_q <= in_last_q ? '0 : str_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && in_last_q) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_last_q) begin
      out_status_q <= status_next;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_status_q};

  // A string end always leaves the decoder state empty.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_last_q |=> str_q.byte_count == '0 && str_q.pending == 2'd0)
    else $error("string state not cleared after last word");

  // The open sequence never expects more continuations than its lead announced.
  a_pending_le_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    str_q.pending != 2'd0 |-> str_q.pending <= str_q.kind)
    else $error("pending continuations exceed sequence kind");

  // A status word appears only after a string end moved into the result register.
  a_out_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(adv && in_last_q))
    else $error("status word without a string end");

  // The input side stalls only with both registers full.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && in_last_q && out_vld_q && !m_axis_tready)
    else $error("input stalled without a full result register");

endmodule
